// ===== rtl/core/frt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types and codes for the fragment reassembly tracker: request and
// response items, and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package frt_pkg;

   localparam int ID_W   = 16;
   localparam int LEN_W  = 12;
   localparam int OFS_W  = 11;
   localparam int BYTE_W = 8;
   localparam int STS_W  = 2;

   localparam logic OP_FRAGMENT = 1'b0;
   localparam logic OP_READ     = 1'b1;

   localparam logic [STS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STS_W-1:0] STATUS_DROP = 2'd1;
   localparam logic [STS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic              operation;
      logic [ID_W-1:0]   packet_id;
      logic [LEN_W-1:0]  packet_length;
      logic [OFS_W-1:0]  fragment_start;
      logic [BYTE_W-1:0] data_byte;
      logic              fragment_end;
      logic [OFS_W-1:0]  read_address;
   } req_type;

   typedef struct packed {
      logic              complete;
      logic [BYTE_W-1:0] read_data;
      logic [STS_W-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic merge_needed;
      logic merge_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/frt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: takes a request, runs the byte update or buffer read, walks the
// range list merge when a fragment ends, and strobes the response.
// ----------------------------------------------------------------------------
module frt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output frt_pkg::cmd_type cmd,
   input  frt_pkg::sts_type sts
);
   import frt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = start;
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.merge_needed) begin
               state_in = ST_MERGE;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MERGE: begin
            if (sts.merge_done) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/core/frt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frt_datapath
// Packet byte buffer, current packet registers and the sorted range list with
// its one-element-per-cycle insert and merge walk.
// ----------------------------------------------------------------------------
module frt_datapath #(
   parameter int MAX_PACKET_BYTES = 2048,
   parameter int MAX_RANGES       = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  frt_pkg::req_type req_item,
   input  frt_pkg::cmd_type cmd,
   output frt_pkg::sts_type sts,
   output frt_pkg::rsp_type rsp_item
);
   import frt_pkg::*;

   localparam int AW = $clog2(MAX_PACKET_BYTES);
   localparam int IW = $clog2(MAX_RANGES);
   localparam int CW = $clog2(MAX_RANGES + 1);

   logic [BYTE_W-1:0] mem [MAX_PACKET_BYTES];

   req_type           req_ff;
   logic [ID_W-1:0]   cur_id_ff;
   logic [LEN_W-1:0]  cur_len_ff;
   logic [LEN_W-1:0]  offset_ff;
   logic [CW-1:0]     count_ff;
   logic [LEN_W-1:0]  rb_ff [MAX_RANGES];
   logic [LEN_W-1:0]  rf_ff [MAX_RANGES];
   logic [LEN_W-1:0]  tb_ff [MAX_RANGES];
   logic [LEN_W-1:0]  tf_ff [MAX_RANGES];
   logic [CW-1:0]     idx_ff;
   logic [CW-1:0]     m_ff;
   logic              ovf_ff;
   logic              ins_used_ff;
   logic              acc_v_ff;
   logic [LEN_W-1:0]  accb_ff, accf_ff;
   logic [LEN_W-1:0]  newb_ff, newf_ff;
   logic [STS_W-1:0]  status_ff;
   logic [BYTE_W-1:0] q_ff;
   logic              rd_oob_ff;

   logic              is_frag, new_pkt;
   logic [LEN_W-1:0]  eff_off, limit, finish;
   logic [LEN_W:0]    position, fin_raw;
   logic              in_range;
   logic [16:0]       wpos_w, rpos_w;
   logic              rd_ok;
   logic              idx_lt, use_new, join_ok, commit_ok;
   logic [LEN_W-1:0]  rd_b, rd_f, e_b, e_f;

   // Byte update for the latched request.
   always_comb begin
      is_frag  = (req_ff.operation == OP_FRAGMENT);
      new_pkt  = (req_ff.packet_id != cur_id_ff) || (req_ff.packet_length != cur_len_ff);
      eff_off  = new_pkt ? '0 : offset_ff;
      limit    = (32'(req_ff.packet_length) < 32'(MAX_PACKET_BYTES)) ?
                 req_ff.packet_length : LEN_W'(MAX_PACKET_BYTES);
      position = (LEN_W+1)'(req_ff.fragment_start) + (LEN_W+1)'(eff_off);
      in_range = position < {1'b0, limit};
      fin_raw  = position + 1'b1;
      finish   = (fin_raw > {1'b0, limit}) ? limit : fin_raw[LEN_W-1:0];
      wpos_w   = 17'(position);
      rpos_w   = 17'(req_ff.read_address);
      rd_ok    = 32'(req_ff.read_address) < 32'(MAX_PACKET_BYTES);
      sts.merge_needed = is_frag && req_ff.fragment_end &&
                         (LEN_W'(req_ff.fragment_start) < finish);

      // Merge walk: one element of the sorted sequence per cycle.
      idx_lt    = idx_ff < count_ff;
      rd_b      = rb_ff[idx_ff[IW-1:0]];
      rd_f      = rf_ff[idx_ff[IW-1:0]];
      use_new   = !ins_used_ff && (!idx_lt || (newb_ff < rd_b));
      e_b       = use_new ? newb_ff : rd_b;
      e_f       = use_new ? newf_ff : rd_f;
      join_ok   = accf_ff >= e_b;
      commit_ok = !ovf_ff && (32'(m_ff) < MAX_RANGES);
      sts.merge_done = ins_used_ff && !idx_lt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_id_ff  <= '0;
         cur_len_ff <= '0;
         offset_ff  <= '0;
         count_ff   <= '0;
      end else if (cmd.exec && is_frag) begin
         cur_id_ff  <= req_ff.packet_id;
         cur_len_ff <= req_ff.packet_length;
         if (req_ff.fragment_end) begin
            offset_ff <= '0;
         end else if (eff_off != {LEN_W{1'b1}}) begin
            offset_ff <= eff_off + 1'b1;
         end else begin
            offset_ff <= eff_off;
         end
         if (new_pkt) count_ff <= '0;
      end else if (cmd.commit && commit_ok) begin
         count_ff <= m_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_item;
      if (cmd.exec) begin
         status_ff   <= (is_frag && !in_range) ? STATUS_DROP : STATUS_OK;
         idx_ff      <= '0;
         m_ff        <= '0;
         ovf_ff      <= 1'b0;
         ins_used_ff <= 1'b0;
         acc_v_ff    <= 1'b0;
         newb_ff     <= LEN_W'(req_ff.fragment_start);
         newf_ff     <= finish;
         rd_oob_ff   <= !rd_ok;
      end
      if (cmd.step) begin
         if (use_new) ins_used_ff <= 1'b1;
         else         idx_ff      <= idx_ff + 1'b1;
         if (!acc_v_ff) begin
            acc_v_ff <= 1'b1;
            accb_ff  <= e_b;
            accf_ff  <= e_f;
         end else if (join_ok) begin
            if (e_f > accf_ff) accf_ff <= e_f;
         end else begin
            if (32'(m_ff) < MAX_RANGES) begin
               tb_ff[m_ff[IW-1:0]] <= accb_ff;
               tf_ff[m_ff[IW-1:0]] <= accf_ff;
               m_ff <= m_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
            accb_ff <= e_b;
            accf_ff <= e_f;
         end
      end
      if (cmd.commit) begin
         if (commit_ok) begin
            for (int k = 0; k < MAX_RANGES; k++) begin
               if (k < 32'(m_ff)) begin
                  rb_ff[k] <= tb_ff[k];
                  rf_ff[k] <= tf_ff[k];
               end else if (k == 32'(m_ff)) begin
                  rb_ff[k] <= accb_ff;
                  rf_ff[k] <= accf_ff;
               end
            end
         end else begin
            status_ff <= STATUS_FULL;
         end
      end
   end

   // Packet buffer, one write or one registered read per request.
   always_ff @(posedge clock) begin
      if (cmd.exec && is_frag && in_range) mem[wpos_w[AW-1:0]] <= req_ff.data_byte;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && !is_frag) q_ff <= mem[rpos_w[AW-1:0]];
   end

   assign rsp_item.complete  = (count_ff == CW'(1)) && (cur_len_ff != '0) &&
                               (rb_ff[0] == '0) && (rf_ff[0] == cur_len_ff);
   assign rsp_item.read_data = (req_ff.operation == OP_READ && !rd_oob_ff) ? q_ff : '0;
   assign rsp_item.status    = status_ff;

   a_commit_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.merge_done)
      else $error("range list committed before the merge walk finished");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_RANGES)
      else $error("range count exceeds list capacity");

   a_new_packet_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && is_frag && new_pkt |=> count_ff == '0)
      else $error("new packet did not clear the range list");

endmodule
`default_nettype wire

// ===== rtl/core/fragment_reassembly_tracker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Reassembles one packet from single-byte fragment requests, tracks received
// byte ranges in a sorted merged list and serves buffer reads.
//
//   Channel   Ports                        Handshake
//   request   start, busy, req_item        taken when start && !busy
//   response  rsp_valid, rsp_item          one-cycle strobe, no back-pressure
//
// Each payload byte or read is executed in the EXEC state before the next
// request can be accepted; the response strobes in the cycle after the buffer
// access. A fragment's last byte whose clipped range is not empty adds a merge
// walk, one list entry per cycle through a single compare-and-merge unit.
// Reset is synchronous and clears the range list and packet registers; the
// buffer is not cleared. The response cannot be stalled.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker #(
   parameter int MAX_PACKET_BYTES = 2048,
   parameter int MAX_RANGES       = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  frt_pkg::req_type req_item,
   output logic             rsp_valid,
   output frt_pkg::rsp_type rsp_item
);
   import frt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   frt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   frt_datapath #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
      .MAX_RANGES       (MAX_RANGES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire
